[design/bgs_pkg.sv]
// bgs_pkg: widths, discharge curve, register map and sequencer states of the
// battery gauge smoother. No dependencies.
package bgs_pkg;

  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = 20;
  localparam int DIVR_W     = 14;
  localparam int TABLE_SIZE = 12;
  localparam int SEG_W      = $clog2(TABLE_SIZE);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [PCT_W-1:0]  FULL_PCT     = 7'd100;
  localparam logic [PCT_W-1:0]  WEIGHT_RESET = 7'd5;
  localparam logic [MV_W-1:0]   CUTOFF_MV    = 13'd3300;
  localparam logic [DIVR_W-1:0] PCT_DIVISOR  = 14'd100;

  localparam logic REG_SMOOTHING = 1'b0;

  localparam logic [DIVR_W-1:0] CURVE_MV [TABLE_SIZE] = '{
    14'd0, 14'd3300, 14'd3400, 14'd3500, 14'd3600, 14'd3700,
    14'd3800, 14'd3900, 14'd4000, 14'd4100, 14'd4200, 14'd9999};
  localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_SIZE] = '{
    7'd0, 7'd0, 7'd13, 7'd22, 7'd39, 7'd53,
    7'd62, 7'd74, 7'd84, 7'd94, 7'd100, 7'd100};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOOKUP,
    ST_PMUL,
    ST_PDIV,
    ST_FINISH
  } state_t;

endpackage

[design/bgs_if.sv]
// bgs_if: valid/ready channel interfaces for samples and results.
// Depends on bgs_pkg.
interface bgs_in_if;
  logic                     valid;
  logic                     ready;
  logic [bgs_pkg::MV_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink (input valid, input sample_mv, output ready);
endinterface

interface bgs_out_if;
  logic                      valid;
  logic                      ready;
  logic [bgs_pkg::MV_W-1:0]  smoothed_mv;
  logic [bgs_pkg::PCT_W-1:0] charge_percent;
  logic                      above_cutoff;

  modport source (output valid, output smoothed_mv, output charge_percent,
                  output above_cutoff, input ready);
  modport sink (input valid, input smoothed_mv, input charge_percent,
                input above_cutoff, output ready);
endinterface

[design/bgs_mac.sv]
// bgs_mac: bit-serial multiply-accumulate, acc = a*ka + b*kb, MSB first,
// one bit of a and b per cycle. Depends on bgs_pkg.
module bgs_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bgs_pkg::MV_W-1:0]    a_in,
  input  logic [bgs_pkg::PCT_W-1:0]   ka_in,
  input  logic [bgs_pkg::MV_W-1:0]    b_in,
  input  logic [bgs_pkg::PCT_W-1:0]   kb_in,
  output logic [bgs_pkg::PROD_W-1:0]  acc,
  output logic                        done
);
  localparam int CNT_W = $clog2(bgs_pkg::MV_W + 1);

  logic [bgs_pkg::MV_W-1:0]   a_r;
  logic [bgs_pkg::MV_W-1:0]   b_r;
  logic [bgs_pkg::PCT_W-1:0]  ka_r;
  logic [bgs_pkg::PCT_W-1:0]  kb_r;
  logic [bgs_pkg::PROD_W-1:0] acc_r;
  logic [bgs_pkg::PROD_W-1:0] acc_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;

  always_comb begin
    acc_nxt = {acc_r[bgs_pkg::PROD_W-2:0], 1'b0}
            + bgs_pkg::PROD_W'(a_r[bgs_pkg::MV_W-1] ? ka_r : '0)
            + bgs_pkg::PROD_W'(b_r[bgs_pkg::MV_W-1] ? kb_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(bgs_pkg::MV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      b_r   <= b_in;
      ka_r  <= ka_in;
      kb_r  <= kb_in;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[bgs_pkg::MV_W-2:0], 1'b0};
      b_r   <= {b_r[bgs_pkg::MV_W-2:0], 1'b0};
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[design/bgs_div.sv]
// bgs_div: restoring radix-2 divider, one quotient bit per cycle.
// Depends on bgs_pkg.
module bgs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bgs_pkg::PROD_W-1:0]  dividend,
  input  logic [bgs_pkg::DIVR_W-1:0]  divisor,
  output logic [bgs_pkg::PROD_W-1:0]  quotient,
  output logic                        done
);
  localparam int CNT_W = $clog2(bgs_pkg::PROD_W + 1);

  logic [bgs_pkg::DIVR_W-1:0] rem_r;
  logic [bgs_pkg::DIVR_W-1:0] dvs_r;
  logic [bgs_pkg::PROD_W-1:0] quo_r;
  logic [bgs_pkg::DIVR_W:0]   trial;
  logic                       ge;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;

  always_comb begin
    trial = {rem_r, quo_r[bgs_pkg::PROD_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(bgs_pkg::PROD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= bgs_pkg::DIVR_W'(ge ? trial - {1'b0, dvs_r} : trial);
      quo_r <= {quo_r[bgs_pkg::PROD_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[design/battery_gauge_smoother.sv]
// battery_gauge_smoother: EMA voltage smoothing and piecewise-linear charge lookup.
// Depends on bgs_pkg, bgs_if, bgs_mac, bgs_div.
//
//   channel   dir  beat payload
//   in_chan   in   sample_mv[12:0]
//   out_chan  out  smoothed_mv[12:0], charge_percent[6:0], above_cutoff
//   apb       in   smoothing_percent at 0x0 (bits 6:0), read back
//
// One sample at a time: it is smoothed and then interpolated, each pass a
// 13-step serial multiply plus a 20-step serial divide; one pass or both
// may be skipped.
// rst_n is synchronous; smoothed state clears to zero.
// A finished result waits in the output register; the next sample is taken
// meanwhile and only stalls at completion if the result is still unread.
module battery_gauge_smoother #(
  parameter int CURVE_POINTS = 12,
  parameter int SAMPLE_BITS  = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bgs_in_if.sink                       in_chan,
  bgs_out_if.source                    out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bgs_pkg::ADDR_W-1:0]   paddr,
  input  logic [bgs_pkg::DATA_W-1:0]   pwdata,
  output logic [bgs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  localparam int USED_POINTS =
    (CURVE_POINTS < bgs_pkg::TABLE_SIZE) ? CURVE_POINTS : bgs_pkg::TABLE_SIZE;
  localparam logic [31:0] SAMPLE_MAX = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

  bgs_pkg::state_t state_r, state_nxt;

  logic [bgs_pkg::PCT_W-1:0]  f_r;
  logic [bgs_pkg::MV_W-1:0]   smooth_r;
  logic [bgs_pkg::PCT_W-1:0]  y0_r;
  logic [bgs_pkg::DIVR_W-1:0] dx_r;
  logic [bgs_pkg::PCT_W-1:0]  pct_r;
  logic                       out_valid_r;
  logic [bgs_pkg::MV_W-1:0]   out_mv_r;
  logic [bgs_pkg::PCT_W-1:0]  out_pct_r;
  logic                       out_cut_r;

  logic                       in_acc;
  logic                       cfg_wr;
  logic                       out_free;
  logic [bgs_pkg::MV_W-1:0]   sample_sat;
  logic [bgs_pkg::PCT_W-1:0]  f_sat;

  logic                       hit;
  logic [bgs_pkg::SEG_W-1:0]  hs;
  logic [bgs_pkg::DIVR_W-1:0] x0, x1;
  logic [bgs_pkg::PCT_W-1:0]  y0, y1;
  logic                       interp;
  logic [bgs_pkg::PROD_W-1:0] pct_sum;

  logic                       mac_start, mac_done;
  logic [bgs_pkg::MV_W-1:0]   mac_a, mac_b;
  logic [bgs_pkg::PCT_W-1:0]  mac_ka, mac_kb;
  logic [bgs_pkg::PROD_W-1:0] mac_acc;
  logic                       div_start, div_done;
  logic [bgs_pkg::PROD_W-1:0] div_dvd, div_quo;
  logic [bgs_pkg::DIVR_W-1:0] div_dvs;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign sample_sat = (32'(in_chan.sample_mv) > SAMPLE_MAX)
                    ? bgs_pkg::MV_W'(SAMPLE_MAX) : in_chan.sample_mv;
  assign f_sat = (f_r > bgs_pkg::FULL_PCT) ? bgs_pkg::FULL_PCT : f_r;

  // first segment whose end point is at or above the smoothed voltage
  always_comb begin
    hit = 1'b0;
    hs  = '0;
    for (int s = USED_POINTS - 2; s >= 0; s--) begin
      if ({1'b0, smooth_r} <= bgs_pkg::CURVE_MV[s+1]) begin
        hit = 1'b1;
        hs  = bgs_pkg::SEG_W'(s);
      end
    end
    x0 = bgs_pkg::CURVE_MV[hs];
    x1 = bgs_pkg::CURVE_MV[bgs_pkg::SEG_W'(hs + 1'b1)];
    y0 = bgs_pkg::CURVE_PCT[hs];
    y1 = bgs_pkg::CURVE_PCT[bgs_pkg::SEG_W'(hs + 1'b1)];
    interp = hit && (x1 > x0) && ({1'b0, smooth_r} >= x0) && (y1 >= y0);
  end

  assign pct_sum = bgs_pkg::PROD_W'(y0_r) + div_quo;

  always_comb begin
    state_nxt = state_r;
    mac_start = 1'b0;
    mac_a     = '0;
    mac_ka    = '0;
    mac_b     = '0;
    mac_kb    = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      bgs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (smooth_r == '0) begin
            state_nxt = bgs_pkg::ST_LOOKUP;
          end else begin
            mac_start = 1'b1;
            mac_a     = sample_sat;
            mac_ka    = f_sat;
            mac_b     = smooth_r;
            mac_kb    = bgs_pkg::FULL_PCT - f_sat;
            state_nxt = bgs_pkg::ST_MUL;
          end
        end
      end
      bgs_pkg::ST_MUL: begin
        if (mac_done) begin
          div_start = 1'b1;
          div_dvd   = mac_acc;
          div_dvs   = bgs_pkg::PCT_DIVISOR;
          state_nxt = bgs_pkg::ST_DIV;
        end
      end
      bgs_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = bgs_pkg::ST_LOOKUP;
        end
      end
      bgs_pkg::ST_LOOKUP: begin
        if (interp) begin
          mac_start = 1'b1;
          mac_a     = bgs_pkg::MV_W'({1'b0, smooth_r} - x0);
          mac_ka    = y1 - y0;
          state_nxt = bgs_pkg::ST_PMUL;
        end else begin
          state_nxt = bgs_pkg::ST_FINISH;
        end
      end
      bgs_pkg::ST_PMUL: begin
        if (mac_done) begin
          div_start = 1'b1;
          div_dvd   = mac_acc;
          div_dvs   = dx_r;
          state_nxt = bgs_pkg::ST_PDIV;
        end
      end
      bgs_pkg::ST_PDIV: begin
        if (div_done) begin
          state_nxt = bgs_pkg::ST_FINISH;
        end
      end
      bgs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bgs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bgs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bgs_pkg::ST_IDLE;
      f_r         <= bgs_pkg::WEIGHT_RESET;
      smooth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr[2] == bgs_pkg::REG_SMOOTHING) begin
        f_r <= pwdata[bgs_pkg::PCT_W-1:0];
      end
      if (state_r == bgs_pkg::ST_IDLE && in_acc && smooth_r == '0) begin
        smooth_r <= sample_sat;
      end else if (state_r == bgs_pkg::ST_DIV && div_done) begin
        smooth_r <= div_quo[bgs_pkg::MV_W-1:0];
      end
      if (state_r == bgs_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bgs_pkg::ST_LOOKUP) begin
      y0_r  <= y0;
      dx_r  <= x1 - x0;
      pct_r <= hit ? y0 : bgs_pkg::FULL_PCT;
    end else if (state_r == bgs_pkg::ST_PDIV && div_done) begin
      pct_r <= (pct_sum > bgs_pkg::PROD_W'(bgs_pkg::FULL_PCT))
             ? bgs_pkg::FULL_PCT : pct_sum[bgs_pkg::PCT_W-1:0];
    end
    if (state_r == bgs_pkg::ST_FINISH && out_free) begin
      out_mv_r  <= smooth_r;
      out_pct_r <= pct_r;
      out_cut_r <= (smooth_r > bgs_pkg::CUTOFF_MV);
    end
  end

  bgs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a_in  (mac_a),
    .ka_in (mac_ka),
    .b_in  (mac_b),
    .kb_in (mac_kb),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  bgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign in_chan.ready           = (state_r == bgs_pkg::ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.smoothed_mv    = out_mv_r;
  assign out_chan.charge_percent = out_pct_r;
  assign out_chan.above_cutoff   = out_cut_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bgs_pkg::REG_SMOOTHING)
                ? bgs_pkg::DATA_W'(f_r) : '0;

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.charge_percent <= bgs_pkg::FULL_PCT)
    else $error("charge percent above full scale");

  a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && smooth_r == '0) |=> smooth_r == $past(sample_sat))
    else $error("first sample not loaded directly");

  a_cutoff_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.above_cutoff ==
      (out_chan.smoothed_mv > bgs_pkg::CUTOFF_MV))
    else $error("cutoff flag disagrees with smoothed voltage");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_start && div_start))
    else $error("multiplier and divider started together");

endmodule

[verif/battery_gauge_smoother_tb.sv]
// battery_gauge_smoother_tb: self-checking bench for the battery gauge smoother.
// Directed and random voltage samples with random idling and stalls, checked against
// an in-bench smoothing and charge-curve predictor. Depends on bgs_pkg, bgs_if, RTL.
`timescale 1ns / 1ps

module battery_gauge_smoother_tb;

  typedef struct packed {
    logic [bgs_pkg::MV_W-1:0]  mv;
    logic [bgs_pkg::PCT_W-1:0] pct;
    logic                      hot;
  } gauge_t;

  localparam int WATCHDOG     = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RAND_ITEMS   = 85;
  localparam logic [bgs_pkg::ADDR_W-1:0] SMOOTHING_ADDR =
    bgs_pkg::ADDR_W'(4 * int'(bgs_pkg::REG_SMOOTHING));

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [bgs_pkg::ADDR_W-1:0] paddr = '0;
  logic [bgs_pkg::DATA_W-1:0] pwdata = '0;
  logic [bgs_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  bgs_in_if  in_if ();
  bgs_out_if out_if ();

  battery_gauge_smoother dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [bgs_pkg::MV_W-1:0]  level_mv;
  logic [bgs_pkg::PCT_W-1:0] weight_pct;
  int knee_mv [12] = '{0, 3300, 3400, 3500, 3600, 3700, 3800, 3900, 4000, 4100, 4200, 9999};
  int knee_pct [12] = '{0, 0, 13, 22, 39, 53, 62, 74, 84, 94, 100, 100};

  logic [bgs_pkg::MV_W-1:0] pending_mv [$];
  gauge_t                   due_results [$];
  int                       errors = 0;
  int                       idle_cycles = 0;
  int                       send_idle = 0;
  int                       recv_stall = 0;
  logic                     in_taken = 1'b0;

  function automatic int charge_at(input int mv);
    int pct;
    bit hit;
    pct = 100;
    hit = 1'b0;
    for (int s = 0; s < 11; s++) begin
      if (!hit && mv <= knee_mv[s+1]) begin
        hit = 1'b1;
        if (knee_mv[s+1] > knee_mv[s] && mv >= knee_mv[s] && knee_pct[s+1] >= knee_pct[s])
          pct = knee_pct[s] + ((knee_pct[s+1] - knee_pct[s]) * (mv - knee_mv[s])) /
                (knee_mv[s+1] - knee_mv[s]);
        else
          pct = knee_pct[s];
      end
    end
    if (pct > 100) pct = 100;
    return pct;
  endfunction

  function automatic gauge_t blend_sample(input logic [bgs_pkg::MV_W-1:0] sample);
    int f;
    int v;
    gauge_t g;
    f = (weight_pct > bgs_pkg::FULL_PCT) ? 100 : int'(weight_pct);
    if (level_mv == '0) v = int'(sample);
    else v = (f * int'(sample) + (100 - f) * int'(level_mv)) / 100;
    if (v > 8191) v = 8191;
    level_mv = bgs_pkg::MV_W'(v);
    g.mv  = bgs_pkg::MV_W'(v);
    g.pct = bgs_pkg::PCT_W'(charge_at(v));
    g.hot = (v > 3300);
    return g;
  endfunction

  task automatic flag(input string what, input int want, input int got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // sample driver and result-side ready
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_mv.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid     <= 1'b1;
        in_if.sample_mv <= pending_mv.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // acceptance, prediction, result check, watchdog
  always @(posedge clk) begin : monitor
    gauge_t want;
    if (rst_n) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) due_results.push_back(blend_sample(in_if.sample_mv));
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          flag("unexpected result beat, smoothed_mv", -1, int'(out_if.smoothed_mv));
        end else begin
          want = due_results.pop_front();
          if (out_if.smoothed_mv !== want.mv)
            flag("smoothed_mv", int'(want.mv), int'(out_if.smoothed_mv));
          if (out_if.charge_percent !== want.pct)
            flag("charge_percent", int'(want.pct), int'(out_if.charge_percent));
          if (out_if.above_cutoff !== want.hot)
            flag("above_cutoff", int'(want.hot), int'(out_if.above_cutoff));
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG) begin
        $display("FAIL battery_gauge_smoother");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic set_weight(input logic [bgs_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SMOOTHING_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    weight_pct = value[bgs_pkg::PCT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== bgs_pkg::DATA_W'(weight_pct))
      flag("smoothing_percent readback", int'(weight_pct), int'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending_mv.size() != 0 || due_results.size() != 0 || in_if.valid)
      @(posedge clk);
  endtask

  task automatic feed_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 70) pending_mv.push_back(bgs_pkg::MV_W'($urandom_range(4400, 3100)));
      else if (r < 95) pending_mv.push_back(bgs_pkg::MV_W'($urandom_range(8191, 0)));
      else if (r < 98) pending_mv.push_back('0);
      else pending_mv.push_back(bgs_pkg::MV_W'(8191));
    end
  endtask

  initial begin
    static int warm_mv [4] = '{4000, 3000, 8191, 2500};
    static int exact_mv [16] = '{0, 0, 3300, 3299, 3301, 3350, 3400, 3456,
                                 3999, 4000, 4150, 4200, 4201, 8191, 1, 0};
    static int hold_mv [3] = '{5000, 100, 8191};
    static int capped_mv [2] = '{1234, 4321};
    static int phase_weight [5] = '{50, 1, -1, 100, -1};
    static int phase_send [5] = '{0, 57, 0, 29, 0};
    static int phase_stall [5] = '{0, 0, 57, 29, 0};

    in_if.valid     = 1'b0;
    in_if.sample_mv = '0;
    out_if.ready    = 1'b0;
    level_mv        = '0;
    weight_pct      = bgs_pkg::WEIGHT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset weight, first sample loads directly
    foreach (warm_mv[i]) pending_mv.push_back(bgs_pkg::MV_W'(warm_mv[i]));
    drain();

    // full weight: smoothed follows the sample, walks the curve breakpoints
    set_weight(32'd100);
    foreach (exact_mv[i]) pending_mv.push_back(bgs_pkg::MV_W'(exact_mv[i]));
    drain();

    // zero weight: load once, then hold
    set_weight(32'd0);
    foreach (hold_mv[i]) pending_mv.push_back(bgs_pkg::MV_W'(hold_mv[i]));
    drain();

    // weight above 100 saturates, upper data bits ignored
    set_weight(32'h0000_0F7F);
    foreach (capped_mv[i]) pending_mv.push_back(bgs_pkg::MV_W'(capped_mv[i]));
    drain();

    for (int p = 0; p < 5; p++) begin
      send_idle  = phase_send[p];
      recv_stall = phase_stall[p];
      if (phase_weight[p] < 0) set_weight(bgs_pkg::DATA_W'($urandom_range(127, 0)));
      else set_weight(bgs_pkg::DATA_W'(phase_weight[p]));
      feed_random(RAND_ITEMS);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) flag("results left over", 0, due_results.size());
    if (errors == 0) begin
      $display("PASS battery_gauge_smoother");
    end else begin
      $display("FAIL battery_gauge_smoother");
    end
    $finish;
  end

endmodule

[sim.f]
design/bgs_pkg.sv
design/bgs_if.sv
design/bgs_mac.sv
design/bgs_div.sv
design/battery_gauge_smoother.sv
verif/battery_gauge_smoother_tb.sv
